// File: rtl/bat_pkg.sv
// Shared constants, command and status codes, and word types for the breakpoint table.
package bat_pkg;

    localparam int ENTRIES = 20;
    localparam int SLOT_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int IDX_W   = 6;

    localparam logic [1:0] CMD_SET       = 2'd0;
    localparam logic [1:0] CMD_CLEAR     = 2'd1;
    localparam logic [1:0] CMD_LOOKUP    = 2'd2;
    localparam logic [1:0] CMD_CLEAR_ALL = 2'd3;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_FULL      = 2'd1;
    localparam logic [1:0] ST_NOT_FOUND = 2'd2;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [15:0] seg_selector;
        logic [31:0] code_offset;
    } bat_in_t;

    typedef struct packed {
        logic [1:0]       status;
        logic             hit;
        logic [IDX_W-1:0] entry_index;
    } bat_out_t;

endpackage

// File: rtl/bat_table.sv
// Breakpoint entry storage with parallel comparators and lowest-index selection.
module bat_table (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              op_en,
    input  bat_pkg::bat_in_t  op_word,
    output bat_pkg::bat_out_t op_result
);
    import bat_pkg::*;

    logic [ENTRIES-1:0] valid_reg;
    logic [ENTRIES-1:0] valid_next;
    logic [15:0]        sel_reg [ENTRIES];
    logic [31:0]        off_reg [ENTRIES];

    logic [ENTRIES-1:0] free_vec;
    logic [ENTRIES-1:0] clr_match;
    logic [ENTRIES-1:0] off_match;
    logic [ENTRIES-1:0] free_oh;
    logic [ENTRIES-1:0] clr_oh;
    logic [ENTRIES-1:0] off_oh;

    function automatic logic [SLOT_W-1:0] oh_to_slot(input logic [ENTRIES-1:0] oh);
        logic [SLOT_W-1:0] slot;
        slot = '0;
        for (int i = 0; i < ENTRIES; i++) begin
            if (oh[i]) begin
                slot = slot | SLOT_W'(i);
            end
        end
        return slot;
    endfunction

    // Compare every entry at once.
    always_comb begin
        for (int i = 0; i < ENTRIES; i++) begin
            free_vec[i]  = !valid_reg[i];
            off_match[i] = valid_reg[i] && (off_reg[i] == op_word.code_offset);
            clr_match[i] = off_match[i] && (sel_reg[i] == op_word.seg_selector);
        end
    end

    // Isolate the lowest set bit of each vector.
    assign free_oh = free_vec  & (~free_vec  + ENTRIES'(1));
    assign clr_oh  = clr_match & (~clr_match + ENTRIES'(1));
    assign off_oh  = off_match & (~off_match + ENTRIES'(1));

    always_comb begin
        valid_next            = valid_reg;
        op_result.status      = ST_OK;
        op_result.hit         = 1'b0;
        op_result.entry_index = '0;
        unique case (op_word.cmd)
            CMD_SET: begin
                if (|free_vec) begin
                    valid_next            = valid_reg | free_oh;
                    op_result.entry_index = IDX_W'(oh_to_slot(free_oh));
                end else begin
                    op_result.status = ST_FULL;
                end
            end
            CMD_CLEAR: begin
                if (|clr_match) begin
                    valid_next            = valid_reg & ~clr_oh;
                    op_result.entry_index = IDX_W'(oh_to_slot(clr_oh));
                end else begin
                    op_result.status = ST_NOT_FOUND;
                end
            end
            CMD_LOOKUP: begin
                if (|off_match) begin
                    op_result.hit         = 1'b1;
                    op_result.entry_index = IDX_W'(oh_to_slot(off_oh));
                end
            end
            default: begin
                valid_next = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (op_en) begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < ENTRIES; i++) begin
            if (op_en && op_word.cmd == CMD_SET && free_oh[i]) begin
                sel_reg[i] <= op_word.seg_selector;
                off_reg[i] <= op_word.code_offset;
            end
        end
    end

    a_set_takes_one: assert property (@(posedge aclk) disable iff (!aresetn)
        (op_en && op_word.cmd == CMD_SET && (|free_vec))
        |=> ($countones(valid_reg) == $past($countones(valid_reg)) + 1))
        else $error("set did not take exactly one entry");

    a_clear_frees_one: assert property (@(posedge aclk) disable iff (!aresetn)
        (op_en && op_word.cmd == CMD_CLEAR && (|clr_match))
        |=> ($countones(valid_reg) + 1 == $past($countones(valid_reg))))
        else $error("clear did not free exactly one entry");

    a_clear_all_empties: assert property (@(posedge aclk) disable iff (!aresetn)
        (op_en && op_word.cmd == CMD_CLEAR_ALL) |=> (valid_reg == '0))
        else $error("clear all left valid entries");

    a_lookup_keeps_table: assert property (@(posedge aclk) disable iff (!aresetn)
        (op_en && op_word.cmd == CMD_LOOKUP) |=> $stable(valid_reg))
        else $error("lookup changed the valid marks");

    a_hit_only_lookup: assert property (@(posedge aclk) disable iff (!aresetn)
        op_result.hit |-> (op_word.cmd == CMD_LOOKUP && op_result.status == ST_OK))
        else $error("hit raised outside a lookup");

endmodule

// File: rtl/breakpoint_address_table.sv
// Top level of the breakpoint address table: input register, table pass, result register.
//
// Usage:
//   The s_ channel carries one command word (cmd, seg_selector, code_offset) per
//   handshake; the m_ channel returns exactly one result word (status, hit,
//   entry_index) per command, in command order.
//   Commands: set takes the lowest free entry, clear frees the lowest entry whose
//   selector and offset both match, lookup matches the offset alone and reports
//   the lowest valid index, clear all frees every entry.
//   Path: an accepted word is held in the input register, passes through the
//   table comparators and is written to the result register when it advances,
//   which waits while the result register is full and m_ready is low.
//   Throughput: one word per cycle while m_ready stays high; the table pass is
//   combinational parallel compares and lowest-index selection, so each command
//   sees the table left by the one before it.
//   Reset: all valid marks clear, both registers empty; stored selectors and
//   offsets are not cleared and are never compared while their entry is free.
//   Stall: while m_ready is low the result word holds; the input register then
//   fills and s_ready drops until the result is taken.
module breakpoint_address_table (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  bat_pkg::bat_in_t  s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output bat_pkg::bat_out_t m_data
);
    import bat_pkg::*;

    logic     in_valid_reg;
    bat_in_t  in_word_reg;
    logic     out_valid_reg;
    bat_out_t out_word_reg;
    bat_out_t table_result;
    logic     advance;

    // Advance the held command when the result slot is free or being drained.
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    // Hold the payload; load only on acceptance.
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_word_reg <= s_data;
        end
    end

    bat_table u_table (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .op_en     (advance),
        .op_word   (in_word_reg),
        .op_result (table_result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_word_reg <= table_result;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_word_reg;

endmodule

// File: tb/bat_table_check.sv
// Channel monitor for the breakpoint table: predicts each result word and compares it.
module bat_table_check (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    input  logic              s_ready,
    input  bat_pkg::bat_in_t  s_data,
    input  logic              m_valid,
    input  logic              m_ready,
    input  bat_pkg::bat_out_t m_data,
    output int                mismatch_count,
    output int                replies_outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    import bat_pkg::*;

    // Own copy of the table contents.
    bit          slot_live [ENTRIES];
    logic [15:0] slot_sel  [ENTRIES];
    logic [31:0] slot_off  [ENTRIES];

    bat_out_t replies_due [$];

    // Run one command against the table copy and return the reply it should give.
    function automatic bat_out_t apply_command(bat_in_t w);
        bat_out_t r;
        bit       done;
        r    = '0;
        done = 1'b0;
        case (w.cmd)
            CMD_SET: begin
                r.status = ST_FULL;
                for (int i = 0; i < ENTRIES; i++) begin
                    if (!done && !slot_live[i]) begin
                        slot_live[i]  = 1'b1;
                        slot_sel[i]   = w.seg_selector;
                        slot_off[i]   = w.code_offset;
                        r.status      = ST_OK;
                        r.entry_index = IDX_W'(i);
                        done          = 1'b1;
                    end
                end
            end
            CMD_CLEAR: begin
                r.status = ST_NOT_FOUND;
                for (int i = 0; i < ENTRIES; i++) begin
                    if (!done && slot_live[i] && slot_sel[i] == w.seg_selector
                            && slot_off[i] == w.code_offset) begin
                        slot_live[i]  = 1'b0;
                        r.status      = ST_OK;
                        r.entry_index = IDX_W'(i);
                        done          = 1'b1;
                    end
                end
            end
            CMD_LOOKUP: begin
                r.status = ST_OK;
                for (int i = 0; i < ENTRIES; i++) begin
                    if (!done && slot_live[i] && slot_off[i] == w.code_offset) begin
                        r.hit         = 1'b1;
                        r.entry_index = IDX_W'(i);
                        done          = 1'b1;
                    end
                end
            end
            default: begin
                r.status = ST_OK;
                foreach (slot_live[i]) slot_live[i] = 1'b0;
            end
        endcase
        return r;
    endfunction

    always @(posedge aclk) begin
        bat_out_t want;
        if (!aresetn) begin
            foreach (slot_live[i]) slot_live[i] = 1'b0;
            replies_due.delete();
            mismatch_count = 0;
        end else begin
            // Check the result word first: it can only belong to an earlier command.
            if (m_valid && m_ready) begin
                if (replies_due.size() == 0) begin
                    $error("result word with no command outstanding: %p", m_data);
                    mismatch_count++;
                end else begin
                    want = replies_due.pop_front();
                    if (m_data.status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, m_data.status);
                        mismatch_count++;
                    end
                    if (m_data.hit !== want.hit) begin
                        $error("hit: expected %0d, got %0d", want.hit, m_data.hit);
                        mismatch_count++;
                    end
                    if (m_data.entry_index !== want.entry_index) begin
                        $error("entry_index: expected %0d, got %0d",
                               want.entry_index, m_data.entry_index);
                        mismatch_count++;
                    end
                end
            end
            if (s_valid && s_ready) begin
                replies_due.push_back(apply_command(s_data));
            end
        end
        replies_outstanding = replies_due.size();
    end

endmodule

// File: tb/testbench.sv
// Top of the breakpoint table testbench: clock, reset, command stimulus and verdict.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import bat_pkg::*;

    // Hang limit, far above the length of any correct run.
    localparam int CYCLE_LIMIT  = 200_000;
    localparam int TOTAL_WORDS  = 420;
    localparam int QUIET_TAIL   = 80;   // last words go out with no idling at all
    localparam int HOLD_CYCLES  = 60;   // long result-side hold-off
    localparam int HOLD_AT      = 120;
    localparam int DRAIN_AT     = 260;
    localparam int POOL         = 16;

    logic     aclk    = 1'b0;
    logic     aresetn = 1'b0;
    logic     s_valid = 1'b0;
    logic     s_ready;
    bat_in_t  s_data  = '0;
    logic     m_valid;
    logic     m_ready = 1'b0;
    bat_out_t m_data;

    int mismatch_count;
    int replies_outstanding;
    int cycles      = 0;
    int words_sent  = 0;
    bit quiet       = 1'b0;  // no idling on either side
    bit hold_results = 1'b0; // asks the receiver for its long hold-off

    // Key pool: most commands reuse these so clears and lookups find live entries.
    logic [15:0] key_sel [POOL];
    logic [31:0] key_off [POOL];

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    breakpoint_address_table i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    bat_table_check i_check (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .s_valid             (s_valid),
        .s_ready             (s_ready),
        .s_data              (s_data),
        .m_valid             (m_valid),
        .m_ready             (m_ready),
        .m_data              (m_data),
        .mismatch_count      (mismatch_count),
        .replies_outstanding (replies_outstanding)
    );

    // Hard stop if the run hangs.
    always @(posedge aclk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Result side: random stall bursts, the one long hold-off on request, none when quiet.
    // At most one assignment to m_ready per falling edge.
    initial begin
        int idle_left;
        idle_left = 0;
        forever begin
            @(negedge aclk);
            if (hold_results) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
                hold_results = 1'b0;
                m_ready <= 1'b1;
            end else if (quiet) begin
                m_ready <= 1'b1;
            end else if (idle_left > 0) begin
                idle_left--;
                m_ready <= 1'b0;
            end else if ($urandom_range(0, 99) < 15) begin
                idle_left = $urandom_range(1, 12) - 1;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Offer one command word and hold it until the block takes it. Called at a falling edge,
    // returns at a falling edge. Valid only drops on the idle path, never just to rise again.
    task automatic send_word(input logic [1:0] c, input logic [15:0] sel,
                             input logic [31:0] off);
        if (!quiet && !hold_results && $urandom_range(0, 99) < 20) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge aclk);
        end
        s_data  <= '{cmd: c, seg_selector: sel, code_offset: off};
        s_valid <= 1'b1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
        words_sent++;
    endtask

    initial begin
        int          pick;
        int          k;
        bit          held;
        bit          drained;
        logic [15:0] sel;
        logic [31:0] off;

        held    = 1'b0;
        drained = 1'b0;
        foreach (key_sel[i]) begin
            key_sel[i] = 16'($urandom);
            key_off[i] = $urandom;
        end
        // Keep the extremes in the pool.
        key_sel[0] = 16'h0000;
        key_off[0] = 32'h0000_0000;
        key_sel[1] = 16'hFFFF;
        key_off[1] = 32'hFFFF_FFFF;
        key_off[2] = key_off[3];   // same offset under two selectors

        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed: empty table misses, extremes, duplicates, lowest-index rules, clear all.
        send_word(CMD_LOOKUP,    16'h0000, 32'h0000_0000);  // lookup on empty table
        send_word(CMD_CLEAR,     16'h0000, 32'h0000_0000);  // clear on empty table
        send_word(CMD_SET,       16'h0000, 32'h0000_0000);
        send_word(CMD_SET,       16'hFFFF, 32'hFFFF_FFFF);
        send_word(CMD_SET,       16'hFFFF, 32'hFFFF_FFFF);  // duplicate takes a second entry
        send_word(CMD_LOOKUP,    16'h0000, 32'hFFFF_FFFF);  // lowest of the two duplicates
        send_word(CMD_SET,       16'hAAAA, 32'h5555_5555);
        send_word(CMD_SET,       16'h5555, 32'hAAAA_AAAA);
        send_word(CMD_CLEAR,     16'hFFFF, 32'hFFFF_FFFF);  // frees only the lower duplicate
        send_word(CMD_LOOKUP,    16'hFFFF, 32'hFFFF_FFFF);  // now finds the upper one
        send_word(CMD_SET,       16'h1234, 32'h0000_0000);  // reuses the freed hole
        send_word(CMD_LOOKUP,    16'h1234, 32'h0000_0000);  // offset-only match, lowest index
        send_word(CMD_CLEAR,     16'h1234, 32'hFFFF_FFFF);  // offset differs: not found
        send_word(CMD_CLEAR,     16'h0001, 32'h0000_0000);  // selector differs: not found
        send_word(CMD_CLEAR,     16'h0000, 32'h0000_0000);
        send_word(CMD_LOOKUP,    16'h0000, 32'h0000_0000);
        send_word(CMD_CLEAR_ALL, 16'hFFFF, 32'hFFFF_FFFF);
        send_word(CMD_LOOKUP,    16'h0000, 32'hAAAA_AAAA);  // miss after clear all
        send_word(CMD_CLEAR,     16'h5555, 32'hAAAA_AAAA);  // gone after clear all

        // Random part: mostly pool keys so entries get hit and freed, some raw noise,
        // and now and then a run of sets that overfills the table.
        while (words_sent < TOTAL_WORDS) begin
            if (!held && words_sent >= HOLD_AT) begin
                // Stop taking results while the sender keeps pushing: fill the pipe.
                held         = 1'b1;
                hold_results = 1'b1;
            end
            if (!drained && words_sent >= DRAIN_AT) begin
                // Pause the sender until every reply is back; drop valid so the
                // word just taken is not offered again.
                drained = 1'b1;
                s_valid <= 1'b0;
                while (replies_outstanding != 0) @(negedge aclk);
            end
            if (words_sent >= TOTAL_WORDS - QUIET_TAIL) quiet = 1'b1;

            pick = $urandom_range(0, 99);
            k    = $urandom_range(0, POOL - 1);
            if (pick < 3) begin
                // Overfill: every set past the last free entry reports full.
                repeat (ENTRIES + 2) begin
                    k = $urandom_range(0, POOL - 1);
                    send_word(CMD_SET, key_sel[k], key_off[k]);
                end
            end else if (pick < 6) begin
                send_word(CMD_CLEAR_ALL, 16'($urandom), $urandom);
            end else if (pick < 46) begin
                if ($urandom_range(0, 99) < 60) begin
                    sel = key_sel[k];
                    off = key_off[k];
                end else begin
                    sel        = 16'($urandom);
                    off        = $urandom;
                    key_sel[k] = sel;
                    key_off[k] = off;
                end
                send_word(CMD_SET, sel, off);
            end else if (pick < 71) begin
                case ($urandom_range(0, 5))
                    0:       send_word(CMD_CLEAR, 16'($urandom), key_off[k]);
                    1:       send_word(CMD_CLEAR, 16'($urandom), $urandom);
                    default: send_word(CMD_CLEAR, key_sel[k], key_off[k]);
                endcase
            end else begin
                if ($urandom_range(0, 99) < 70) begin
                    send_word(CMD_LOOKUP, 16'($urandom), key_off[k]);
                end else begin
                    send_word(CMD_LOOKUP, 16'($urandom), $urandom);
                end
            end
        end
        s_valid <= 1'b0;

        // Drain, then wait on for any stray result word.
        while (replies_outstanding != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);

        if (mismatch_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
